@@ hdl/wpts_pkg.sv @@
// Shared sizes, codes, and control types for the weighted priority task stacks.
// Used by wpts_ctrl, wpts_dp and weighted_priority_task_stacks_core.
`timescale 1ns / 1ps

package wpts_pkg;

  // Sizing
  localparam int PRIORITY_LEVELS = 4;
  localparam int STACK_DEPTH     = 16;
  localparam int ID_BITS         = 16;

  localparam int NUM_POOLS = 2;
  localparam int NUM_CATS  = 2;

  localparam int LVL_W      = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int PTR_W      = $clog2(STACK_DEPTH);
  localparam int FILL_W     = $clog2(STACK_DEPTH + 1);
  localparam int STK_W      = 2 + LVL_W;
  localparam int NUM_STK    = 2 ** STK_W;
  localparam int ADDR_W     = STK_W + PTR_W;
  localparam int STORE_DEPTH = 2 ** ADDR_W;
  localparam int TOTAL_W    =
    $clog2(NUM_POOLS * NUM_CATS * PRIORITY_LEVELS * STACK_DEPTH + 1);
  localparam int POOL_SUM_W = $clog2(NUM_CATS * PRIORITY_LEVELS * STACK_DEPTH + 1);

  // Port field widths
  localparam int OP_W     = 2;
  localparam int PRIO_W   = 2;
  localparam int TID_W    = 16;
  localparam int STATUS_W = 3;
  localparam int QUEUED_W = 9;
  localparam int REMOVED_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_PERIOD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFERRED_TURNS = 1'd1;
  localparam logic [CFG_W-1:0]     RATIO_RESET = 4'd6;
  localparam logic [CFG_W-1:0]     PREF_RESET  = 4'd5;

  // Controller to datapath
  typedef struct packed {
    logic latch;   // capture input transaction
    logic reduce;  // bring turn counter below period, one subtract
    logic exec;    // perform the operation
    logic load;    // move result into output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_reduce;
  } dp_sts_t;

  function automatic logic [STK_W-1:0] stk_idx(input logic p, input logic c,
                                               input logic [LVL_W-1:0] l);
    stk_idx = {p, c, l};
  endfunction

endpackage

@@ hdl/wpts_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wpts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/wpts_ctrl.sv @@
// Sequencing FSM for the task stacks: accept, execute, deliver.
// Depends on wpts_pkg.
`timescale 1ns / 1ps

module wpts_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  wpts_pkg::dp_sts_t     sts,
  output wpts_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = !((state_r == S_IDLE) || ((state_r == S_FIN) && out_free));

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_reduce) begin
          cmd.reduce = 1'b1;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load = 1'b1;
          if (in_valid) begin
            cmd.latch = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/wpts_dp.sv @@
// Datapath: stack fill counters, turn counters, config registers, task store,
// result and output registers. Depends on wpts_pkg and wpts_ram.
`timescale 1ns / 1ps

module wpts_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wpts_pkg::ctrl_cmd_t                   cmd,
  output wpts_pkg::dp_sts_t                     sts,
  input  logic [wpts_pkg::OP_W-1:0]             in_op,
  input  logic                                  in_pool,
  input  logic                                  in_category,
  input  logic [wpts_pkg::PRIO_W-1:0]           in_priority_req,
  input  logic [wpts_pkg::TID_W-1:0]            in_task_id,
  input  logic                                  cfg_we,
  input  logic [wpts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpts_pkg::CFG_W-1:0]            cfg_wdata,
  output logic [wpts_pkg::STATUS_W-1:0]         out_status,
  output logic [wpts_pkg::TID_W-1:0]            out_task_id_out,
  output logic                                  out_served_category,
  output logic [wpts_pkg::PRIO_W-1:0]           out_served_priority,
  output logic [wpts_pkg::QUEUED_W-1:0]         out_queued_count,
  output logic [wpts_pkg::REMOVED_W-1:0]        out_removed_count
);

  // Captured transaction
  logic [wpts_pkg::OP_W-1:0]   op_r;
  logic                        pool_r;
  logic                        cat_r;
  logic [wpts_pkg::LVL_W-1:0]  lvl_r;
  logic [wpts_pkg::ID_BITS-1:0] id_r;

  // Control state
  logic [wpts_pkg::FILL_W-1:0]  fill_r [wpts_pkg::NUM_STK];
  logic [wpts_pkg::CFG_W-1:0]   turn_r [wpts_pkg::NUM_POOLS];
  logic [wpts_pkg::TOTAL_W-1:0] total_r;
  logic [wpts_pkg::CFG_W-1:0]   ratio_r;
  logic [wpts_pkg::CFG_W-1:0]   pref_r;

  // Result registers
  logic [wpts_pkg::STATUS_W-1:0]   res_status_r;
  logic                            res_cat_r;
  logic [wpts_pkg::LVL_W-1:0]      res_lvl_r;
  logic [wpts_pkg::POOL_SUM_W-1:0] res_removed_r;

  // Output registers
  logic [wpts_pkg::STATUS_W-1:0]  out_status_r;
  logic [wpts_pkg::TID_W-1:0]     out_tid_r;
  logic                           out_cat_r;
  logic [wpts_pkg::PRIO_W-1:0]    out_prio_r;
  logic [wpts_pkg::QUEUED_W-1:0]  out_queued_r;
  logic [wpts_pkg::REMOVED_W-1:0] out_removed_r;

  logic [wpts_pkg::CFG_W-1:0]      period;
  logic [wpts_pkg::CFG_W-1:0]      cur_turn;
  logic [wpts_pkg::CFG_W-1:0]      turn_inc;
  logic                            held;
  logic                            pref_cat;
  logic                            found_pref;
  logic [wpts_pkg::LVL_W-1:0]      lvl_pref, lvl_alt;
  logic                            sel_cat;
  logic [wpts_pkg::LVL_W-1:0]      sel_lvl;
  logic [wpts_pkg::STK_W-1:0]      sel_idx;
  logic [wpts_pkg::FILL_W-1:0]     sel_top;
  logic [wpts_pkg::POOL_SUM_W-1:0] removed;
  logic [wpts_pkg::STK_W-1:0]      push_idx;
  logic [wpts_pkg::FILL_W-1:0]     push_fill;
  logic                            push_full;
  logic                            ram_we, ram_re;
  logic [wpts_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [wpts_pkg::ID_BITS-1:0]    ram_rdata;

  assign period   = (ratio_r == '0) ? wpts_pkg::CFG_W'(1) : ratio_r;
  assign cur_turn = turn_r[pool_r];
  assign turn_inc = cur_turn + wpts_pkg::CFG_W'(1);
  assign pref_cat = (cur_turn < pref_r) ? 1'b0 : 1'b1;

  // Pool occupancy, lowest nonempty level per category, and pool total
  always_comb begin
    held       = 1'b0;
    found_pref = 1'b0;
    lvl_pref   = '0;
    lvl_alt    = '0;
    removed    = '0;
    for (int c = 0; c < wpts_pkg::NUM_CATS; c++) begin
      for (int l = 0; l < wpts_pkg::PRIORITY_LEVELS; l++) begin
        removed = removed + wpts_pkg::POOL_SUM_W'(
          fill_r[wpts_pkg::stk_idx(pool_r, c[0], wpts_pkg::LVL_W'(l))]);
        if (fill_r[wpts_pkg::stk_idx(pool_r, c[0], wpts_pkg::LVL_W'(l))] != '0) begin
          held = 1'b1;
        end
      end
    end
    // descending scan so the lowest level wins
    for (int l = wpts_pkg::PRIORITY_LEVELS - 1; l >= 0; l--) begin
      if (fill_r[wpts_pkg::stk_idx(pool_r, pref_cat, wpts_pkg::LVL_W'(l))] != '0) begin
        found_pref = 1'b1;
        lvl_pref   = wpts_pkg::LVL_W'(l);
      end
      if (fill_r[wpts_pkg::stk_idx(pool_r, !pref_cat, wpts_pkg::LVL_W'(l))] != '0) begin
        lvl_alt   = wpts_pkg::LVL_W'(l);
      end
    end
  end

  assign sel_cat  = found_pref ? pref_cat : !pref_cat;
  assign sel_lvl  = found_pref ? lvl_pref : lvl_alt;
  assign sel_idx  = wpts_pkg::stk_idx(pool_r, sel_cat, sel_lvl);
  assign sel_top  = fill_r[sel_idx] - wpts_pkg::FILL_W'(1);

  assign push_idx  = wpts_pkg::stk_idx(pool_r, cat_r, lvl_r);
  assign push_fill = fill_r[push_idx];
  assign push_full = (push_fill == wpts_pkg::FILL_W'(wpts_pkg::STACK_DEPTH));

  assign sts.need_reduce = (op_r == wpts_pkg::OP_POP) && held && (cur_turn >= period);

  assign ram_we    = cmd.exec && (op_r == wpts_pkg::OP_PUSH) && !push_full;
  assign ram_waddr = {push_idx, push_fill[wpts_pkg::PTR_W-1:0]};
  assign ram_re    = cmd.exec && (op_r == wpts_pkg::OP_POP) && held;
  assign ram_raddr = {sel_idx, sel_top[wpts_pkg::PTR_W-1:0]};

  wpts_ram #(
    .WIDTH (wpts_pkg::ID_BITS),
    .DEPTH (wpts_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (id_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Transaction capture (priority saturates to the last level)
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      pool_r <= in_pool;
      cat_r  <= in_category;
      if (32'(in_priority_req) >= wpts_pkg::PRIORITY_LEVELS) begin
        lvl_r <= wpts_pkg::LVL_W'(wpts_pkg::PRIORITY_LEVELS - 1);
      end else begin
        lvl_r <= wpts_pkg::LVL_W'(in_priority_req);
      end
      id_r   <= wpts_pkg::ID_BITS'(in_task_id);
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= wpts_pkg::RATIO_RESET;
      pref_r  <= wpts_pkg::PREF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wpts_pkg::REG_RATIO_PERIOD:    ratio_r <= cfg_wdata;
        wpts_pkg::REG_PREFERRED_TURNS: pref_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stack fills, turn counters, total count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < wpts_pkg::NUM_STK; s++) begin
        fill_r[s] <= '0;
      end
      for (int p = 0; p < wpts_pkg::NUM_POOLS; p++) begin
        turn_r[p] <= '0;
      end
      total_r <= '0;
    end else if (cmd.reduce) begin
      turn_r[pool_r] <= cur_turn - period;
    end else if (cmd.exec) begin
      case (op_r)
        wpts_pkg::OP_PUSH: begin
          if (!push_full) begin
            fill_r[push_idx] <= push_fill + wpts_pkg::FILL_W'(1);
            total_r          <= total_r + wpts_pkg::TOTAL_W'(1);
          end
        end
        wpts_pkg::OP_POP: begin
          if (held) begin
            fill_r[sel_idx] <= sel_top;
            turn_r[pool_r]  <= (turn_inc == period) ? '0 : turn_inc;
            total_r         <= total_r - wpts_pkg::TOTAL_W'(1);
          end
        end
        wpts_pkg::OP_CLEAR: begin
          for (int c = 0; c < wpts_pkg::NUM_CATS; c++) begin
            for (int l = 0; l < wpts_pkg::PRIORITY_LEVELS; l++) begin
              fill_r[wpts_pkg::stk_idx(pool_r, c[0], wpts_pkg::LVL_W'(l))] <= '0;
            end
          end
          total_r <= total_r - wpts_pkg::TOTAL_W'(removed);
        end
        default: ;
      endcase
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_cat_r     <= 1'b0;
      res_lvl_r     <= '0;
      res_removed_r <= '0;
      case (op_r)
        wpts_pkg::OP_PUSH: begin
          res_status_r <= push_full ? wpts_pkg::ST_FULL : wpts_pkg::ST_PUSHED;
        end
        wpts_pkg::OP_POP: begin
          if (held) begin
            res_status_r <= wpts_pkg::ST_POPPED;
            res_cat_r    <= sel_cat;
            res_lvl_r    <= sel_lvl;
          end else begin
            res_status_r <= wpts_pkg::ST_EMPTY;
          end
        end
        wpts_pkg::OP_CLEAR: begin
          res_status_r  <= wpts_pkg::ST_CLEARED;
          res_removed_r <= removed;
        end
        default: begin
          res_status_r <= wpts_pkg::ST_EMPTY;
        end
      endcase
    end
  end

  // Output register; the store's read data holds until the next pop
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r  <= res_status_r;
      out_tid_r     <= (res_status_r == wpts_pkg::ST_POPPED) ?
                       wpts_pkg::TID_W'(ram_rdata) : '0;
      out_cat_r     <= res_cat_r;
      out_prio_r    <= wpts_pkg::PRIO_W'(res_lvl_r);
      out_queued_r  <= wpts_pkg::QUEUED_W'(total_r);
      out_removed_r <= wpts_pkg::REMOVED_W'(res_removed_r);
    end
  end

  assign out_status          = out_status_r;
  assign out_task_id_out     = out_tid_r;
  assign out_served_category = out_cat_r;
  assign out_served_priority = out_prio_r;
  assign out_queued_count    = out_queued_r;
  assign out_removed_count   = out_removed_r;

endmodule

@@ hdl/weighted_priority_task_stacks_core.sv @@
// Weighted priority task stacks: top level over wpts_ctrl and wpts_dp (wpts_pkg, wpts_ram).
// Flow: accept, execute, then output load (held while the result side stalls); a pop
//   of a nonempty pool whose turn counter sits at or above ratio_period first subtracts
//   the period until it is below. New input is taken only in idle or at the prior load.
// Reset (rst_n low, synchronous): stacks empty, turn counters and count zero, config
//   to its defaults; task store contents are left as they are.
`timescale 1ns / 1ps

module weighted_priority_task_stacks_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input transaction channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wpts_pkg::OP_W-1:0]             in_op,
  input  logic                                  in_pool,
  input  logic                                  in_category,
  input  logic [wpts_pkg::PRIO_W-1:0]           in_priority_req,
  input  logic [wpts_pkg::TID_W-1:0]            in_task_id,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wpts_pkg::STATUS_W-1:0]         out_status,
  output logic [wpts_pkg::TID_W-1:0]            out_task_id_out,
  output logic                                  out_served_category,
  output logic [wpts_pkg::PRIO_W-1:0]           out_served_priority,
  output logic [wpts_pkg::QUEUED_W-1:0]         out_queued_count,
  output logic [wpts_pkg::REMOVED_W-1:0]        out_removed_count,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wpts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpts_pkg::CFG_W-1:0]            cfg_wdata
);

  wpts_pkg::ctrl_cmd_t cmd;
  wpts_pkg::dp_sts_t   sts;

  // Config writes are registered directly and always taken.
  assign cfg_ready = 1'b1;

  // The controller walks each transaction through execute and output load.
  // The output register lets a new transaction be accepted while the previous
  // result still waits downstream.
  wpts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: 16 LIFO stacks (pool x category x level) share one task store
  // addressed by {pool, category, level, stack pointer}; fill counters are flops.
  wpts_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_pool             (in_pool),
    .in_category         (in_category),
    .in_priority_req     (in_priority_req),
    .in_task_id          (in_task_id),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_status          (out_status),
    .out_task_id_out     (out_task_id_out),
    .out_served_category (out_served_category),
    .out_served_priority (out_served_priority),
    .out_queued_count    (out_queued_count),
    .out_removed_count   (out_removed_count)
  );

  // One transaction at a time: after an accept the input is stalled.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while previous one still executing");

  // Only a pop carries task, category and level fields.
  a_nonpop_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != wpts_pkg::ST_POPPED) |->
      (out_task_id_out == '0) && (out_served_category == 1'b0) &&
      (out_served_priority == '0))
    else $error("non-pop result carries pop fields");

  // Removed count is reported only by a clear.
  a_removed_only_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != wpts_pkg::ST_CLEARED) |-> (out_removed_count == '0))
    else $error("removed count set on non-clear result");

  // A loaded result is presented on the next cycle.
  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("result loaded but not presented");

endmodule

@@ verif/wpts_sched_checker.sv @@
// Scoreboard for weighted_priority_task_stacks_core: watches the input, result
// and register write channels, predicts each result and compares it field by field.
// Depends on wpts_pkg.
`timescale 1ns / 1ps

module wpts_sched_checker
  import wpts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic                 in_pool,
  input  logic                 in_category,
  input  logic [PRIO_W-1:0]    in_priority_req,
  input  logic [TID_W-1:0]     in_task_id,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic [TID_W-1:0]     out_task_id_out,
  input  logic                 out_served_category,
  input  logic [PRIO_W-1:0]    out_served_priority,
  input  logic [QUEUED_W-1:0]  out_queued_count,
  input  logic [REMOVED_W-1:0] out_removed_count,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatch_total,
  output int                   results_due
);

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TID_W-1:0]     task_id;
    logic                 served_cat;
    logic [PRIO_W-1:0]    served_prio;
    logic [QUEUED_W-1:0]  queued;
    logic [REMOVED_W-1:0] removed;
  } sched_result_t;

  // shadow scheduler state
  logic [TID_W-1:0] id_stack [NUM_POOLS][NUM_CATS][PRIORITY_LEVELS][STACK_DEPTH];
  int unsigned      depth_now [NUM_POOLS][NUM_CATS][PRIORITY_LEVELS];
  int unsigned      turn_ctr [NUM_POOLS];
  int unsigned      held_total;
  logic [CFG_W-1:0] period_reg;
  logic [CFG_W-1:0] pref_reg;

  sched_result_t    sched_due [$];

  initial begin
    mismatch_total = 0;
    results_due    = 0;
  end

  function automatic sched_result_t predict_sched_result(
    input logic [OP_W-1:0] op, input logic pool, input logic cat,
    input logic [PRIO_W-1:0] prio, input logic [TID_W-1:0] tid);
    sched_result_t r;
    int unsigned   lvl, period, turn, held, k, l;
    logic          want_cat, c_sel, found;
    r = '0;
    lvl = (prio >= PRIORITY_LEVELS) ? PRIORITY_LEVELS - 1 : prio;
    case (op)
      OP_PUSH: begin
        if (depth_now[pool][cat][lvl] >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          id_stack[pool][cat][lvl][depth_now[pool][cat][lvl]] = tid;
          depth_now[pool][cat][lvl]++;
          held_total++;
          r.status = ST_PUSHED;
        end
      end
      OP_POP: begin
        held = 0;
        for (k = 0; k < NUM_CATS; k++)
          for (l = 0; l < PRIORITY_LEVELS; l++)
            held += depth_now[pool][k][l];
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // zero period acts as one; a stale counter is folded first
          period = (period_reg == 0) ? 1 : period_reg;
          turn = turn_ctr[pool] % period;
          want_cat = (turn < pref_reg) ? 1'b0 : 1'b1;
          turn_ctr[pool] = (turn + 1) % period;
          found = 1'b0;
          for (k = 0; k < NUM_CATS; k++) begin
            c_sel = want_cat ^ k[0];
            for (l = 0; l < PRIORITY_LEVELS; l++)
              if (!found && depth_now[pool][c_sel][l] > 0) begin
                depth_now[pool][c_sel][l]--;
                r.task_id = id_stack[pool][c_sel][l][depth_now[pool][c_sel][l]];
                r.served_cat = c_sel;
                r.served_prio = PRIO_W'(l);
                found = 1'b1;
              end
          end
          held_total--;
          r.status = ST_POPPED;
        end
      end
      OP_CLEAR: begin
        held = 0;
        for (k = 0; k < NUM_CATS; k++)
          for (l = 0; l < PRIORITY_LEVELS; l++) begin
            held += depth_now[pool][k][l];
            depth_now[pool][k][l] = 0;
          end
        held_total -= held;
        r.status = ST_CLEARED;
        r.removed = held[REMOVED_W-1:0];
      end
      default: r.status = ST_EMPTY;
    endcase
    r.queued = held_total[QUEUED_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      foreach (depth_now[p, c, l]) depth_now[p][c][l] = 0;
      turn_ctr[0] = 0;
      turn_ctr[1] = 0;
      held_total  = 0;
      period_reg  = RATIO_RESET;
      pref_reg    = PREF_RESET;
      sched_due.delete();
      results_due = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RATIO_PERIOD:    period_reg = cfg_wdata;
          REG_PREFERRED_TURNS: pref_reg = cfg_wdata;
          default: ;
        endcase
      end
      // results first: a transaction accepted this edge cannot answer at once
      if (out_valid && !out_stall) begin
        if (sched_due.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected result, expected none, got status %0d",
                   $time, out_status);
        end else begin
          want = sched_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("task_id_out", want.task_id, out_task_id_out);
          check_field("served_category", want.served_cat, out_served_category);
          check_field("served_priority", want.served_prio, out_served_priority);
          check_field("queued_count", want.queued, out_queued_count);
          check_field("removed_count", want.removed, out_removed_count);
        end
      end
      if (in_valid && !in_stall)
        sched_due.push_back(predict_sched_result(in_op, in_pool, in_category,
                                                 in_priority_req, in_task_id));
      results_due = sched_due.size();
    end
  end

endmodule

@@ verif/weighted_priority_task_stacks_core_test.sv @@
// Top of the weighted_priority_task_stacks_core testbench: clock, reset, stimulus,
// result-side stalls and the verdict. Depends on wpts_pkg, the core and
// wpts_sched_checker.
`timescale 1ns / 1ps

module weighted_priority_task_stacks_core_test;
  import wpts_pkg::*;

  // op code 3 is not assigned; the core must answer it as an empty pool
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic            POOL_CPU  = 1'b0;
  localparam logic            POOL_IO   = 1'b1;

  localparam int PHASES       = 10;
  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_HOLD    = 300;   // cycles of result-side back pressure
  localparam int HOLD_AFTER   = 400;   // transactions sent before the long hold
  // the slowest legal run stays well under this limit
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op;
  logic                 in_pool;
  logic                 in_category;
  logic [PRIO_W-1:0]    in_priority_req;
  logic [TID_W-1:0]     in_task_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic [TID_W-1:0]     out_task_id_out;
  logic                 out_served_category;
  logic [PRIO_W-1:0]    out_served_priority;
  logic [QUEUED_W-1:0]  out_queued_count;
  logic [REMOVED_W-1:0] out_removed_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int mismatch_total;
  int results_due;
  int sent_count     = 0;
  int cycle_count    = 0;
  bit calm           = 1'b0;  // no idling on either side
  bit long_hold_done = 1'b0;

  // register settings per phase; phase 0 runs on reset values, the last ones
  // get random values. Large periods come before small ones so the turn
  // counters are left above the new period.
  logic [CFG_W-1:0] period_plan [PHASES] = '{6, 0, 15, 1, 15, 3, 2, 15, 0, 0};
  logic [CFG_W-1:0] pref_plan   [PHASES] = '{5, 0, 15, 0, 0, 1, 15, 7, 0, 0};

  always #1 clk = ~clk;

  weighted_priority_task_stacks_core i_dut (.*);

  wpts_sched_checker i_checker (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("weighted_priority_task_stacks_core verification failed");
      $finish;
    end
  end

  // Result side: runs of taking results, broken by short stalls; once, well into
  // the run, a long stall so the core backs up and stalls its input.
  initial begin : result_sink
    int run_len, hold_len;
    out_stall = 1'b0;
    forever begin
      run_len = $urandom_range(1, 40);
      repeat (run_len) @(negedge clk);
      if (!calm) begin
        if (!long_hold_done && sent_count >= HOLD_AFTER) begin
          hold_len = LONG_HOLD;
          long_hold_done = 1'b1;
        end else begin
          hold_len = $urandom_range(1, 16);
        end
        out_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Offer one transaction, maybe after a gap. Valid is left high on return; the
  // next call keeps or lowers it, or the caller lowers it, always in the same time step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic pool,
                           input logic cat, input logic [PRIO_W-1:0] prio,
                           input logic [TID_W-1:0] tid);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_op           = op;
    in_pool         = pool;
    in_category     = cat;
    in_priority_req = prio;
    in_task_id      = tid;
    in_valid        = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // Register write, only once every result is back and the core is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random traffic in bursts of one flavor each:
  //   fill   - mostly pushes, builds up deep stacks and high counts
  //   drain  - mostly pops, runs pools dry and hits the empty answer
  //   narrow - one stack hammered until it rejects pushes
  //   mixed  - everything
  task automatic run_phase(input int n_items);
    int                done, burst, mode, roll;
    logic [OP_W-1:0]   op;
    logic              pool, cat, fpool, fcat;
    logic [PRIO_W-1:0] prio, fprio;
    logic [TID_W-1:0]  tid;
    done = 0;
    while (done < n_items) begin
      mode  = $urandom_range(0, 3);
      burst = $urandom_range(20, 60);
      if (burst > n_items - done)
        burst = n_items - done;
      fpool = $urandom_range(0, 1);
      fcat  = $urandom_range(0, 1);
      fprio = $urandom_range(0, 3);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        pool = $urandom_range(0, 1);
        cat  = $urandom_range(0, 1);
        prio = $urandom_range(0, 3);
        tid  = $urandom_range(0, 65535);
        case (mode)
          0: op = (roll < 80) ? OP_PUSH : (roll < 95) ? OP_POP :
                  (roll < 97) ? OP_CLEAR : OP_UNUSED;
          1: op = (roll < 15) ? OP_PUSH : (roll < 92) ? OP_POP :
                  (roll < 96) ? OP_CLEAR : OP_UNUSED;
          2: begin
            op   = (roll < 85) ? OP_PUSH : OP_POP;
            pool = fpool;
            cat  = fcat;
            prio = fprio;
          end
          default: op = (roll < 45) ? OP_PUSH : (roll < 88) ? OP_POP :
                        (roll < 95) ? OP_CLEAR : OP_UNUSED;
        endcase
        send_item(op, pool, cat, prio, tid);
        done++;
      end
    end
  endtask

  initial begin : stimulus
    int ph;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_PUSH;
    in_pool         = POOL_CPU;
    in_category     = 1'b0;
    in_priority_req = '0;
    in_task_id      = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_RATIO_PERIOD;
    cfg_wdata       = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed, on reset settings (period 6, five turns prefer category 0).
    send_item(OP_POP,    POOL_CPU, 1'b0, 2'd0, 16'h0000);  // empty pool
    send_item(OP_CLEAR,  POOL_IO,  1'b0, 2'd0, 16'h0000);  // clear of nothing
    send_item(OP_UNUSED, POOL_CPU, 1'b0, 2'd0, 16'h0000);
    send_item(OP_PUSH,   POOL_CPU, 1'b0, 2'd0, 16'h0000);
    send_item(OP_PUSH,   POOL_CPU, 1'b1, 2'd3, 16'hFFFF);
    send_item(OP_PUSH,   POOL_CPU, 1'b0, 2'd3, 16'h5A5A);
    send_item(OP_PUSH,   POOL_IO,  1'b1, 2'd3, 16'hFFFF);
    send_item(OP_PUSH,   POOL_IO,  1'b0, 2'd0, 16'hA5A5);
    send_item(OP_PUSH,   POOL_CPU, 1'b1, 2'd0, 16'h8001);
    send_item(OP_UNUSED, POOL_IO,  1'b1, 2'd3, 16'hFFFF);  // fields must not matter
    // category 0 first, lowest level first, then fall back to category 1
    send_item(OP_POP,    POOL_CPU, 1'b1, 2'd3, 16'hFFFF);
    send_item(OP_POP,    POOL_CPU, 1'b0, 2'd0, 16'h0000);
    send_item(OP_POP,    POOL_CPU, 1'b0, 2'd0, 16'h0000);
    send_item(OP_POP,    POOL_CPU, 1'b0, 2'd0, 16'h0000);
    send_item(OP_POP,    POOL_CPU, 1'b0, 2'd0, 16'h0000);  // drained
    send_item(OP_CLEAR,  POOL_IO,  1'b1, 2'd3, 16'hFFFF);  // removes two
    send_item(OP_POP,    POOL_IO,  1'b0, 2'd0, 16'h0000);

    // Random phases, each under its own register setting; the last one
    // runs without idling.
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1)
        calm = 1'b1;
      if (ph > 0) begin
        if (ph >= PHASES - 2) begin
          write_reg(REG_RATIO_PERIOD, CFG_W'($urandom_range(0, 15)));
          write_reg(REG_PREFERRED_TURNS, CFG_W'($urandom_range(0, 15)));
        end else begin
          write_reg(REG_RATIO_PERIOD, period_plan[ph]);
          write_reg(REG_PREFERRED_TURNS, pref_plan[ph]);
        end
      end
      run_phase(RANDOM_ITEMS / PHASES);
    end
    in_valid = 1'b0;

    // drain, then wait quietly for anything stray
    while (results_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatch_total == 0 && results_due == 0) begin
      $display("weighted_priority_task_stacks_core verification clean");
    end else begin
      $display("weighted_priority_task_stacks_core verification failed");
    end
    $finish;
  end

endmodule

@@ weighted_priority_task_stacks_core.f @@
hdl/wpts_pkg.sv
hdl/wpts_ram.sv
hdl/wpts_ctrl.sv
hdl/wpts_dp.sv
hdl/weighted_priority_task_stacks_core.sv
verif/wpts_sched_checker.sv
verif/weighted_priority_task_stacks_core_test.sv
